FILE: design/imu_ctf_pkg.sv
// Shared types, constants and helper functions of the IMU tilt filter.
// No dependencies; every module of the block imports this package.
`default_nettype none

package imu_ctf_pkg;

  // Accel counts to g in Q16.16: 65536 / 16384 counts per g is an exact shift.
  localparam int unsigned ACCEL_SHIFT = 2;
  // Gyro increment: |count * dt| * 65536 / 131000000 = |count * dt| * 1024 / 2046875.
  localparam logic [20:0] GYRO_DEN_ODD = 21'd2046875;
  // floor(2^52 / 2046875); the estimate taken from product bits [63:42] is low by
  // at most one and is corrected by one compare.
  localparam logic [31:0] GYRO_RECIP = 32'd2200231879;
  // Gyro division steps: reciprocal estimate, then correction.
  localparam int unsigned DIV_STEPS = 2;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam logic [15:0] INV_GAIN = 16'd39797;
  localparam logic [16:0] BLEND_ONE = 17'd65536;
  localparam logic signed [25:0] ANGLE_90 = 26'sd5898240;
  localparam logic signed [28:0] ANGLE_LIMIT = 29'sd11796480;

  // atan(2^-i) in degrees with 24 fraction bits
  localparam logic [29:0] ATAN_TAB [24] = '{
    30'd754974720, 30'd445687602, 30'd235489089, 30'd119537938, 30'd60000934,
    30'd30029717, 30'd15018523, 30'd7509720, 30'd3754917, 30'd1877466,
    30'd938734, 30'd469367, 30'd234684, 30'd117342, 30'd58671, 30'd29335,
    30'd14668, 30'd7334, 30'd3667, 30'd1833, 30'd917, 30'd458, 30'd229, 30'd115
  };

  typedef enum logic [2:0] {
    REG_ACCEL_BLEND, REG_GYRO_BLEND,
    REG_ACCEL_OFF_X, REG_ACCEL_OFF_Y, REG_ACCEL_OFF_Z,
    REG_GYRO_OFF_X, REG_GYRO_OFF_Y, REG_GYRO_OFF_Z
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_AVG, ST_AVG_UPD, ST_DIV, ST_C1_INIT, ST_C1_ITER,
    ST_MAG, ST_C2_INIT, ST_C2_ITER, ST_FIRST, ST_BLEND_MUL, ST_BLEND_SUM
  } state_e;

  typedef struct packed {
    logic       load;
    logic       prep;
    logic       avg_mul;
    logic       avg_upd;
    logic       div_step;
    logic       cord_init;
    logic       cord_step;
    logic       cord_pass;
    logic       mag;
    logic       first;
    logic       blend_mul;
    logic       blend_sum;
    logic [4:0] step;
  } cmd_t;

  // Round the table entry to 16 fraction bits.
  function automatic logic signed [25:0] atan_step(logic [4:0] i);
    logic [29:0] t;
    t = ATAN_TAB[i] + 30'd128;
    return $signed({4'b0000, t[29:8]});
  endfunction

  function automatic logic signed [24:0] sat_angle(logic signed [28:0] v);
    logic signed [24:0] r;
    if (v > ANGLE_LIMIT) r = ANGLE_LIMIT[24:0];
    else if (v < -ANGLE_LIMIT) r = -ANGLE_LIMIT[24:0];
    else r = v[24:0];
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/imu_ctf_datapath.sv
// Datapath: configuration registers, accel average, gyro dividers, shared CORDIC
// and the blend stage. Driven by imu_ctf_ctrl commands; uses imu_ctf_pkg.
`default_nettype none

module imu_ctf_datapath import imu_ctf_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [16:0]  cfg_data_i,
  input  wire cmd_t         cmd_i,
  input  wire logic [111:0] in_data_i,
  output logic [81:0]       out_data_o
);

  logic [16:0] accel_blend_q, gyro_blend_q;
  logic signed [15:0] aoff_q [3];
  logic signed [15:0] goff_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_blend_q <= 17'd6554;
      gyro_blend_q  <= 17'd64881;
      for (int k = 0; k < 3; k++) begin
        aoff_q[k] <= '0;
        goff_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ACCEL_BLEND: accel_blend_q <= cfg_data_i;
        REG_GYRO_BLEND:  gyro_blend_q  <= cfg_data_i;
        REG_ACCEL_OFF_X: aoff_q[0] <= cfg_data_i[15:0];
        REG_ACCEL_OFF_Y: aoff_q[1] <= cfg_data_i[15:0];
        REG_ACCEL_OFF_Z: aoff_q[2] <= cfg_data_i[15:0];
        REG_GYRO_OFF_X:  goff_q[0] <= cfg_data_i[15:0];
        REG_GYRO_OFF_Y:  goff_q[1] <= cfg_data_i[15:0];
        REG_GYRO_OFF_Z:  goff_q[2] <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic [16:0] ab, gb, gb_inv;
  assign ab     = (accel_blend_q > BLEND_ONE) ? BLEND_ONE : accel_blend_q;
  assign gb     = (gyro_blend_q > BLEND_ONE) ? BLEND_ONE : gyro_blend_q;
  assign gb_inv = BLEND_ONE - gb;

  // Payload registers
  logic signed [15:0] raw_q [6];
  logic [15:0]        dt_q;
  logic signed [18:0] g_q [3];
  logic signed [33:0] gp_q [3];
  logic signed [38:0] avgp_q [3];
  logic signed [19:0] f_q [3];
  logic [31:0]        mg_q [3];
  logic [22:0]        w_q [3];
  logic               neg_q [3];
  logic signed [23:0] x_q, y_q, mag_q;
  logic signed [25:0] z_q, acc_pitch_q, acc_roll_q;
  logic               zero_q;
  logic signed [43:0] pr_g_q, pr_a_q, pp_g_q, pp_a_q;
  logic signed [24:0] roll_q, pitch_q;
  logic [31:0]        yaw_q;
  logic [81:0]        out_q;
  logic               accel_first_q, angle_first_q;

  // Signed gyro increments from the divider quotients
  logic signed [23:0] inc [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      inc[k] = neg_q[k] ? -$signed({1'b0, w_q[k]}) : $signed({1'b0, w_q[k]});
    end
  end

  // Gyro division by the constant: reciprocal estimate, then remainder check.
  logic [63:0] recip_prod [3];
  logic [41:0] div_rem [3];
  logic        div_fix [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      recip_prod[k] = mg_q[k] * GYRO_RECIP;
      div_rem[k]    = {mg_q[k], 10'b0} - w_q[k] * GYRO_DEN_ODD;
      div_fix[k]    = div_rem[k] >= 42'(GYRO_DEN_ODD);
    end
  end

  // CORDIC start vector
  logic signed [23:0] cx, cy;
  assign cx = cmd_i.cord_pass ? mag_q : 24'(f_q[2]);
  assign cy = cmd_i.cord_pass ? -24'(f_q[0]) : 24'(f_q[1]);

  logic signed [23:0] dx, dy;
  logic signed [25:0] a_step;
  assign dx     = y_q >>> cmd_i.step;
  assign dy     = x_q >>> cmd_i.step;
  assign a_step = atan_step(cmd_i.step);

  logic signed [25:0] acc_roll_now;
  assign acc_roll_now = zero_q ? '0 : z_q;

  logic signed [40:0] mag_prod;
  assign mag_prod = x_q * $signed({1'b0, INV_GAIN});

  logic signed [25:0] roll_in, pitch_in;
  assign roll_in  = 26'(roll_q) + 26'(inc[1]);
  assign pitch_in = 26'(pitch_q) + 26'(inc[0]);

  logic signed [44:0] r_sum, p_sum;
  assign r_sum = 45'(pr_g_q) + 45'(pr_a_q);
  assign p_sum = 45'(pp_g_q) + 45'(pp_a_q);

  logic signed [24:0] roll_new, pitch_new;
  assign roll_new  = sat_angle(r_sum[44:16]);
  assign pitch_new = sat_angle(p_sum[44:16]);

  // First-sample flags and angle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_first_q <= 1'b1;
      angle_first_q <= 1'b1;
      for (int k = 0; k < 3; k++) f_q[k] <= '0;
      roll_q  <= '0;
      pitch_q <= '0;
      yaw_q   <= '0;
    end else begin
      if (cmd_i.avg_upd) begin
        accel_first_q <= 1'b0;
        for (int k = 0; k < 3; k++) begin
          f_q[k] <= accel_first_q ? 20'(g_q[k]) : f_q[k] + avgp_q[k][35:16];
        end
      end
      if (cmd_i.first && angle_first_q) begin
        angle_first_q <= 1'b0;
        roll_q  <= sat_angle(29'(acc_roll_now));
        pitch_q <= sat_angle(29'(acc_pitch_q));
      end
      if (cmd_i.blend_mul) yaw_q <= yaw_q + 32'(inc[2]);
      if (cmd_i.blend_sum) begin
        roll_q  <= roll_new;
        pitch_q <= pitch_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int k = 0; k < 6; k++) raw_q[k] <= in_data_i[16*k +: 16];
      dt_q <= in_data_i[111:96];
    end
    if (cmd_i.prep) begin
      for (int k = 0; k < 3; k++) begin
        g_q[k]  <= 19'(17'(raw_q[k]) - 17'(aoff_q[k])) <<< ACCEL_SHIFT;
        gp_q[k] <= 34'(17'(raw_q[k+3]) - 17'(goff_q[k])) * $signed({18'b0, dt_q});
      end
    end
    if (cmd_i.avg_mul) begin
      for (int k = 0; k < 3; k++) begin
        avgp_q[k] <= (21'(g_q[k]) - 21'(f_q[k])) * $signed({1'b0, ab});
      end
    end
    // Load the dividers with |product| and its sign.
    if (cmd_i.avg_upd) begin
      for (int k = 0; k < 3; k++) begin
        logic [33:0] mg;
        mg = gp_q[k][33] ? 34'(-gp_q[k]) : 34'(gp_q[k]);
        neg_q[k] <= gp_q[k][33];
        mg_q[k]  <= mg[31:0];
      end
    end
    // First step takes the estimate, second adds one where the remainder allows.
    if (cmd_i.div_step) begin
      for (int k = 0; k < 3; k++) begin
        if (cmd_i.step == 5'd0) w_q[k] <= 23'(recip_prod[k][63:42]);
        else w_q[k] <= w_q[k] + 23'(div_fix[k]);
      end
    end
    if (cmd_i.cord_init) begin
      zero_q <= (cx == '0) && (cy == '0);
      if (cx < 0) begin
        if (cy >= 0) begin
          x_q <= cy; y_q <= -cx; z_q <= ANGLE_90;
        end else begin
          x_q <= -cy; y_q <= cx; z_q <= -ANGLE_90;
        end
      end else begin
        x_q <= cx; y_q <= cy; z_q <= '0;
      end
    end
    if (cmd_i.cord_step) begin
      if (y_q >= 0) begin
        x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + a_step;
      end else begin
        x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - a_step;
      end
    end
    if (cmd_i.mag) begin
      acc_pitch_q <= acc_roll_now;
      mag_q       <= mag_prod[39:16];
    end
    if (cmd_i.first) acc_roll_q <= acc_roll_now;
    if (cmd_i.blend_mul) begin
      pr_g_q <= roll_in * $signed({1'b0, gb});
      pr_a_q <= acc_roll_q * $signed({1'b0, gb_inv});
      pp_g_q <= pitch_in * $signed({1'b0, gb});
      pp_a_q <= acc_pitch_q * $signed({1'b0, gb_inv});
    end
    if (cmd_i.blend_sum) out_q <= {yaw_q, pitch_new, roll_new};
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

FILE: design/imu_ctf_ctrl.sv
// Controller: sequences one sample through the datapath and owns the
// stream handshakes and the step counter. Uses imu_ctf_pkg.
`default_nettype none

module imu_ctf_ctrl import imu_ctf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output cmd_t      cmd_o
);

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free, last_div, last_cord;

  assign out_free  = !out_valid_q || out_ready_i;
  assign last_div  = cnt_q == 5'(DIV_STEPS - 1);
  assign last_cord = cnt_q == 5'(CORDIC_STEPS - 1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_PREP;
      ST_PREP:      state_d = ST_AVG;
      ST_AVG:       state_d = ST_AVG_UPD;
      ST_AVG_UPD:   state_d = ST_DIV;
      ST_DIV:       if (last_div) state_d = ST_C1_INIT;
      ST_C1_INIT:   state_d = ST_C1_ITER;
      ST_C1_ITER:   if (last_cord) state_d = ST_MAG;
      ST_MAG:       state_d = ST_C2_INIT;
      ST_C2_INIT:   state_d = ST_C2_ITER;
      ST_C2_ITER:   if (last_cord) state_d = ST_FIRST;
      ST_FIRST:     state_d = ST_BLEND_MUL;
      ST_BLEND_MUL: state_d = ST_BLEND_SUM;
      ST_BLEND_SUM: if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.step      = cnt_q;
    in_ready_o      = 1'b0;
    cnt_d           = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_PREP:    cmd_o.prep = 1'b1;
      ST_AVG:     cmd_o.avg_mul = 1'b1;
      ST_AVG_UPD: cmd_o.avg_upd = 1'b1;
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = last_div ? '0 : cnt_q + 5'd1;
      end
      ST_C1_INIT: cmd_o.cord_init = 1'b1;
      ST_C1_ITER: begin
        cmd_o.cord_step = 1'b1;
        cnt_d = last_cord ? '0 : cnt_q + 5'd1;
      end
      ST_MAG: cmd_o.mag = 1'b1;
      ST_C2_INIT: begin
        cmd_o.cord_init = 1'b1;
        cmd_o.cord_pass = 1'b1;
      end
      ST_C2_ITER: begin
        cmd_o.cord_step = 1'b1;
        cmd_o.cord_pass = 1'b1;
        cnt_d = last_cord ? '0 : cnt_q + 5'd1;
      end
      ST_FIRST:     cmd_o.first = 1'b1;
      ST_BLEND_MUL: cmd_o.blend_mul = 1'b1;
      ST_BLEND_SUM: cmd_o.blend_sum = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.blend_sum) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == ST_PREP)
    else $error("accepted sample did not start processing");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.prep, cmd_o.avg_mul, cmd_o.avg_upd, cmd_o.div_step,
              cmd_o.cord_init, cmd_o.cord_step, cmd_o.mag, cmd_o.first,
              cmd_o.blend_mul, cmd_o.blend_sum}))
    else $error("more than one datapath command");
  a_cord_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.cord_step |-> cnt_q < 5'(CORDIC_STEPS))
    else $error("CORDIC step index out of range");
  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.blend_sum |=> out_valid_o)
    else $error("result written without valid");
`endif

endmodule

`default_nettype wire

FILE: design/imu_complementary_tilt_filter.sv
// Top level of the IMU complementary tilt filter: joins the controller and
// the datapath. Depends on imu_ctf_pkg, imu_ctf_ctrl and imu_ctf_datapath.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  raw six-axis sample + time step
//  m_axis    out        m_axis_tvalid / m_axis_tready  roll/pitch Q9.16, yaw Q16.16 deg
//  cfg       in         cfg_we_i                       register index + write data
//
// From transfer to result a sample passes the setup steps (prep, average and
// average update), the reciprocal gyro division (estimate, then correction), two
// passes of one load and 16 steps through the one shared CORDIC unit, and the
// scaling and blending steps; the next transfer is taken once the block is idle.
// Reset clears the filter state and loads the register defaults; the first
// sample after reset loads the accel average and the tilt angles directly.
// The result register lets the next sample transfer in while a result waits;
// the block only stalls at its final step if the previous result is still held.
`default_nettype none

module imu_complementary_tilt_filter import imu_ctf_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw,
  // step_time_us (16 bits each, from bit 0 up)
  input  wire logic [111:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // roll_angle [24:0], pitch_angle [49:25], yaw_angle [81:50], zero fill [87:82]
  output logic [87:0]       m_axis_tdata,
  input  wire logic         cfg_we_i,
  input  wire logic [2:0]   cfg_idx_i,
  input  wire logic [16:0]  cfg_data_i
);

  cmd_t        cmd;
  logic [81:0] out_data;

  // Sequence each sample and own both handshakes.
  imu_ctf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // Arithmetic, filter state and configuration registers.
  imu_ctf_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .in_data_i  (s_axis_tdata),
    .out_data_o (out_data)
  );

  // Pad the result to whole bytes.
  assign m_axis_tdata = {6'b000000, out_data};

endmodule

`default_nettype wire
